// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the solver core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define LUS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another one on the same edge
`define LUS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lus_pkg.sv =====
// ----------------------------------------------------------------------------
// lus_pkg
// Shared types, constants and fixed-point helpers of the 3x3 LU solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lus_pkg;

   localparam int DATA_W              = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // One accepted system plus the early zero-pivot class
   typedef struct packed {
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m13;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
      logic signed [DATA_W-1:0] m23;
      logic signed [DATA_W-1:0] m31;
      logic signed [DATA_W-1:0] m32;
      logic signed [DATA_W-1:0] m33;
      logic signed [DATA_W-1:0] rhs1;
      logic signed [DATA_W-1:0] rhs2;
      logic signed [DATA_W-1:0] rhs3;
      logic                     zero_pivot;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Clamp a wide signed value to the 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

// ===== rtl/core/lus_front.sv =====
// ----------------------------------------------------------------------------
// lus_front
// Input stage: registers each request beat and flags a zero first pivot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lus_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [31:0]           req_m11,
   input  logic signed [31:0]           req_m12,
   input  logic signed [31:0]           req_m13,
   input  logic signed [31:0]           req_m21,
   input  logic signed [31:0]           req_m22,
   input  logic signed [31:0]           req_m23,
   input  logic signed [31:0]           req_m31,
   input  logic signed [31:0]           req_m32,
   input  logic signed [31:0]           req_m33,
   input  logic signed [31:0]           req_rhs1,
   input  logic signed [31:0]           req_rhs2,
   input  logic signed [31:0]           req_rhs3,
   output logic                         push,
   input  logic                         push_ready,
   output lus_pkg::item_type            push_item
);

   logic              valid_ff;
   logic              valid_in;
   lus_pkg::item_type item_ff;
   logic              take;

   // Take a new beat when the holding register is empty or drains now
   assign push      = valid_ff;
   assign push_item = item_ff;
   assign req_stall = valid_ff && !push_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (push && push_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload and classify the first pivot
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.m11        <= req_m11;
         item_ff.m12        <= req_m12;
         item_ff.m13        <= req_m13;
         item_ff.m21        <= req_m21;
         item_ff.m22        <= req_m22;
         item_ff.m23        <= req_m23;
         item_ff.m31        <= req_m31;
         item_ff.m32        <= req_m32;
         item_ff.m33        <= req_m33;
         item_ff.rhs1       <= req_rhs1;
         item_ff.rhs2       <= req_rhs2;
         item_ff.rhs3       <= req_rhs3;
         item_ff.zero_pivot <= (req_m11 == 32'sd0);
      end
   end

endmodule

// ===== rtl/core/lus_queue.sv =====
// ----------------------------------------------------------------------------
// lus_queue
// Short FIFO of classified systems between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lus_queue #(
   parameter int QUEUE_DEPTH = lus_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              push_ready,
   input  lus_pkg::item_type push_item,
   input  logic              pop,
   output lus_pkg::head_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lus_pkg::item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [CNT_W-1:0]           count_ff;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_push    = push && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/lus_div.sv =====
// ----------------------------------------------------------------------------
// lus_div
// Restoring divider: sat((n << FRAC_BITS) / d), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lus_div #(
   parameter int FRAC_BITS = lus_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] numer,
   input  logic signed [31:0] denom,
   output logic               done,
   output logic signed [31:0] quot
);

   localparam int QW    = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);

   logic [QW-1:0]    num_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      dmag_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [32:0]      trial;
   logic             qbit;
   logic [31:0]      nmag;
   logic [31:0]      dmag;

   // Magnitudes of the operands
   assign nmag = numer[31] ? (~numer + 32'd1) : numer;
   assign dmag = denom[31] ? (~denom + 32'd1) : denom;

   // One restoring step
   assign trial = {rem_ff, num_ff[QW-1]};
   assign qbit  = (trial >= {1'b0, dmag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= {nmag, FRAC_BITS'(0)};
         rem_ff  <= '0;
         dmag_ff <= dmag;
         neg_ff  <= numer[31] ^ denom[31];
      end else if (cnt_ff != '0) begin
         num_ff <= {num_ff[QW-2:0], qbit};
         rem_ff <= qbit ? 32'(trial - {1'b0, dmag_ff}) : trial[31:0];
      end
   end

   // Apply sign and clamp to the 32-bit range
   always_comb begin
      if (neg_ff) begin
         if (num_ff > QW'(33'h0_8000_0000)) begin
            quot = 32'sh8000_0000;
         end else begin
            quot = -$signed(num_ff[31:0]);
         end
      end else begin
         if (num_ff > QW'(33'h0_7FFF_FFFF)) begin
            quot = 32'sh7FFF_FFFF;
         end else begin
            quot = $signed(num_ff[31:0]);
         end
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/core/lus_back.sv =====
// ----------------------------------------------------------------------------
// lus_back
// Sequencer: LU factoring and substitution on a shared multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lus_back #(
   parameter int FRAC_BITS = lus_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  lus_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sol1,
   output logic signed [31:0] rsp_sol2,
   output logic signed [31:0] rsp_sol3,
   output logic signed [31:0] rsp_low21,
   output logic signed [31:0] rsp_low31,
   output logic signed [31:0] rsp_low32,
   output logic signed [31:0] rsp_up22,
   output logic signed [31:0] rsp_up23,
   output logic signed [31:0] rsp_up33,
   output logic               rsp_singular
);

   // Step codes, run in this order
   localparam logic [3:0] OP_L21 = 4'd0;
   localparam logic [3:0] OP_L31 = 4'd1;
   localparam logic [3:0] OP_U22 = 4'd2;
   localparam logic [3:0] OP_U23 = 4'd3;
   localparam logic [3:0] OP_L32 = 4'd4;
   localparam logic [3:0] OP_U33 = 4'd5;
   localparam logic [3:0] OP_R2  = 4'd6;
   localparam logic [3:0] OP_R3  = 4'd7;
   localparam logic [3:0] OP_X3  = 4'd8;
   localparam logic [3:0] OP_X2  = 4'd9;
   localparam logic [3:0] OP_X1  = 4'd10;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_SUB  = 7'b0001000,
      S_SAT  = 7'b0010000,
      S_DIVW = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [3:0]         op_ff;
   logic               term_ff;
   logic               sing_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] l21_ff, l31_ff, l32_ff, u22_ff, u23_ff, u33_ff;
   logic signed [31:0] r2_ff, r3_ff, x1_ff, x2_ff, x3_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] base_s, ma0, mb0, ma1, mb1, dvs;
   logic [1:0]         nterm;
   logic               use_div;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_in;
   logic signed [31:0] acc_sat;
   logic signed [31:0] store_val;
   logic               do_store;
   logic               zero_hit;
   logic               out_free;
   logic               div_start;
   logic               div_done;
   logic signed [31:0] div_q;
   lus_pkg::item_type  it;

   assign it = head.item;

   // Step table: base value, product terms and divisor of each step
   always_comb begin
      base_s  = '0;
      ma0     = '0;
      mb0     = '0;
      ma1     = '0;
      mb1     = '0;
      dvs     = it.m11;
      nterm   = 2'd0;
      use_div = 1'b0;
      unique case (op_ff)
         OP_L21: begin base_s = it.m21; use_div = 1'b1; end
         OP_L31: begin base_s = it.m31; use_div = 1'b1; end
         OP_U22: begin base_s = it.m22; nterm = 2'd1; ma0 = l21_ff; mb0 = it.m12; end
         OP_U23: begin base_s = it.m23; nterm = 2'd1; ma0 = l21_ff; mb0 = it.m13; end
         OP_L32: begin
            base_s = it.m32; nterm = 2'd1; ma0 = l31_ff; mb0 = it.m12;
            use_div = 1'b1; dvs = u22_ff;
         end
         OP_U33: begin
            base_s = it.m33; nterm = 2'd2; ma0 = l31_ff; mb0 = it.m13;
            ma1 = l32_ff; mb1 = u23_ff;
         end
         OP_R2:  begin base_s = it.rhs2; nterm = 2'd1; ma0 = l21_ff; mb0 = it.rhs1; end
         OP_R3:  begin
            base_s = it.rhs3; nterm = 2'd2; ma0 = l31_ff; mb0 = it.rhs1;
            ma1 = l32_ff; mb1 = r2_ff;
         end
         OP_X3:  begin base_s = r3_ff; use_div = 1'b1; dvs = u33_ff; end
         OP_X2:  begin
            base_s = r2_ff; nterm = 2'd1; ma0 = u23_ff; mb0 = x3_ff;
            use_div = 1'b1; dvs = u22_ff;
         end
         OP_X1:  begin
            base_s = it.rhs1; nterm = 2'd2; ma0 = it.m12; mb0 = x2_ff;
            ma1 = it.m13; mb1 = x3_ff; use_div = 1'b1;
         end
         default: begin base_s = '0; end
      endcase
   end

   // Shared multiplier, registered before the subtract
   assign mul_a   = term_ff ? ma1 : ma0;
   assign mul_b   = term_ff ? mb1 : mb0;
   assign prod_in = mul_a * mul_b;
   assign acc_sat = lus_pkg::sat32(acc_ff);

   // Shared divider
   assign div_start = (state_ff == S_SAT) && use_div;

   lus_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (acc_sat),
      .denom (dvs),
      .done  (div_done),
      .quot  (div_q)
   );

   // Result of the current step
   assign do_store  = ((state_ff == S_SAT) && !use_div) || ((state_ff == S_DIVW) && div_done);
   assign store_val = (state_ff == S_DIVW) ? div_q : acc_sat;
   assign zero_hit  = do_store && (store_val == 32'sd0) && ((op_ff == OP_U22) || (op_ff == OP_U33));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_OUT) && out_free;

   // Sequence the steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               state_in = head.item.zero_pivot ? S_OUT : S_LOAD;
            end
         end
         S_LOAD: state_in = (nterm == 2'd0) ? S_SAT : S_MUL;
         S_MUL:  state_in = S_SUB;
         S_SUB: begin
            if ({1'b0, term_ff} == nterm - 2'd1) begin
               state_in = S_SAT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_SAT: begin
            if (use_div) begin
               state_in = S_DIVW;
            end else if (zero_hit || (op_ff == OP_X1)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               state_in = (op_ff == OP_X1) ? S_OUT : S_LOAD;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         op_ff   <= OP_L21;
         sing_ff <= head.item.zero_pivot;
      end
      if (state_ff == S_LOAD) begin
         acc_ff  <= 64'(base_s);
         term_ff <= 1'b0;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == S_SUB) begin
         acc_ff  <= acc_ff - (prod_ff >>> FRAC_BITS);
         term_ff <= 1'b1;
      end
      if (do_store) begin
         op_ff <= op_ff + 4'd1;
         if (zero_hit) begin
            sing_ff <= 1'b1;
         end
         case (op_ff)
            OP_L21: l21_ff <= store_val;
            OP_L31: l31_ff <= store_val;
            OP_U22: u22_ff <= store_val;
            OP_U23: u23_ff <= store_val;
            OP_L32: l32_ff <= store_val;
            OP_U33: u33_ff <= store_val;
            OP_R2:  r2_ff  <= store_val;
            OP_R3:  r3_ff  <= store_val;
            OP_X3:  x3_ff  <= store_val;
            OP_X2:  x2_ff  <= store_val;
            OP_X1:  x1_ff  <= store_val;
            default: ;
         endcase
      end
   end

   // Output register: hold while stalled, zero the fields on a singular system
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_singular <= sing_ff;
         rsp_sol1     <= sing_ff ? '0 : x1_ff;
         rsp_sol2     <= sing_ff ? '0 : x2_ff;
         rsp_sol3     <= sing_ff ? '0 : x3_ff;
         rsp_low21    <= sing_ff ? '0 : l21_ff;
         rsp_low31    <= sing_ff ? '0 : l31_ff;
         rsp_low32    <= sing_ff ? '0 : l32_ff;
         rsp_up22     <= sing_ff ? '0 : u22_ff;
         rsp_up23     <= sing_ff ? '0 : u23_ff;
         rsp_up33     <= sing_ff ? '0 : u33_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/lu_solve_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// lu_solve_3x3_unit
// Solves A*x = b for 3x3 systems in signed fixed point by Doolittle LU.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat carries the nine matrix entries and the
// three right-hand side entries, taken when req_valid is high and req_stall
// low. Response channel (rsp_*): one beat per request, in order, carrying the
// solution, the L and U entries and the singular flag; fields are zero when a
// pivot is zero. Results are held steady while rsp_stall is high.
// A beat is registered in the front register and then written to the queue;
// the sequencer then runs eleven steps on one shared multiplier and one
// restoring divider. Each of the six divisions holds the sequencer until the
// divider is done, after the product terms of its step, so the divider sets
// most of the time that one system occupies the back end. A system with a
// zero first pivot skips the steps and goes straight to the response. The
// back end takes one system at a time, so throughput is one system per
// back-end occupancy, set mostly by the shared divider.
// The front keeps accepting into a QUEUE_DEPTH queue, while it has room, as the back end works
// or the response waits. Synchronous reset empties front, queue and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lu_solve_3x3_unit #(
   parameter int FRAC_BITS   = lus_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = lus_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_m11,
   input  logic signed [31:0] req_m12,
   input  logic signed [31:0] req_m13,
   input  logic signed [31:0] req_m21,
   input  logic signed [31:0] req_m22,
   input  logic signed [31:0] req_m23,
   input  logic signed [31:0] req_m31,
   input  logic signed [31:0] req_m32,
   input  logic signed [31:0] req_m33,
   input  logic signed [31:0] req_rhs1,
   input  logic signed [31:0] req_rhs2,
   input  logic signed [31:0] req_rhs3,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sol1,
   output logic signed [31:0] rsp_sol2,
   output logic signed [31:0] rsp_sol3,
   output logic signed [31:0] rsp_low21,
   output logic signed [31:0] rsp_low31,
   output logic signed [31:0] rsp_low32,
   output logic signed [31:0] rsp_up22,
   output logic signed [31:0] rsp_up23,
   output logic signed [31:0] rsp_up33,
   output logic               rsp_singular
);

   logic              push;
   logic              push_ready;
   lus_pkg::item_type push_item;
   logic              pop;
   lus_pkg::head_type head;

   lus_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_m11    (req_m11),
      .req_m12    (req_m12),
      .req_m13    (req_m13),
      .req_m21    (req_m21),
      .req_m22    (req_m22),
      .req_m23    (req_m23),
      .req_m31    (req_m31),
      .req_m32    (req_m32),
      .req_m33    (req_m33),
      .req_rhs1   (req_rhs1),
      .req_rhs2   (req_rhs2),
      .req_rhs3   (req_rhs3),
      .push       (push),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   lus_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop        (pop),
      .head       (head)
   );

   lus_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sol1     (rsp_sol1),
      .rsp_sol2     (rsp_sol2),
      .rsp_sol3     (rsp_sol3),
      .rsp_low21    (rsp_low21),
      .rsp_low31    (rsp_low31),
      .rsp_low32    (rsp_low32),
      .rsp_up22     (rsp_up22),
      .rsp_up23     (rsp_up23),
      .rsp_up33     (rsp_up33),
      .rsp_singular (rsp_singular)
   );

   // A singular beat carries zero sol1, up22 and low21 fields
   `LUS_ASSERT_IMPL(a_sing_zero, rsp_valid && rsp_singular, (rsp_sol1 == 32'sd0) && (rsp_up22 == 32'sd0) && (rsp_low21 == 32'sd0), "singular beat with nonzero fields")
   // A regular beat has nonzero up22 and up33 pivots
   `LUS_ASSERT_IMPL(a_pivots, rsp_valid && !rsp_singular, (rsp_up22 != 32'sd0) && (rsp_up33 != 32'sd0), "regular beat with zero pivot")
   // The back end only pops a present entry
   `LUS_ASSERT_ALWAYS(a_pop_head, !pop || head.valid, "pop from empty queue")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 fixed-point LU solver. Applies a directed
// table, then random systems under varied request and response idling, and
// checks every response beat against a bit-exact solution predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int FRAC       = lus_pkg::FRAC_BITS_DEFAULT;
   localparam int LIMIT      = 4_000_000;
   localparam int TAIL       = 800;
   localparam int PHASE_ITEMS = 450;
   localparam longint Q_HI   = 64'sd2147483647;
   localparam longint Q_LO   = -64'sd2147483648;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NMAX = 32'sh8000_0000;

   typedef logic signed [31:0] word_type;
   // m11..m33, rhs1..rhs3
   typedef struct {
      word_type v[12];
   } system_type;
   // sol1..3, low21, low31, low32, up22, up23, up33, then singular
   typedef struct {
      word_type f[9];
      logic     sing;
   } solution_type;
   typedef struct {
      word_type v[12];
      bit       zero_pivot;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   word_type req_v[12];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   word_type rsp_f[9];
   logic rsp_singular;

   solution_type solution_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int beats_checked = 0;
   int singular_seen = 0;
   int cycles = 0;

   initial begin
      for (int i = 0; i < 12; i++) req_v[i] = '0;
   end

   lu_solve_3x3_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m11(req_v[0]), .req_m12(req_v[1]), .req_m13(req_v[2]),
      .req_m21(req_v[3]), .req_m22(req_v[4]), .req_m23(req_v[5]),
      .req_m31(req_v[6]), .req_m32(req_v[7]), .req_m33(req_v[8]),
      .req_rhs1(req_v[9]), .req_rhs2(req_v[10]), .req_rhs3(req_v[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sol1(rsp_f[0]), .rsp_sol2(rsp_f[1]), .rsp_sol3(rsp_f[2]),
      .rsp_low21(rsp_f[3]), .rsp_low31(rsp_f[4]), .rsp_low32(rsp_f[5]),
      .rsp_up22(rsp_f[6]), .rsp_up23(rsp_f[7]), .rsp_up33(rsp_f[8]),
      .rsp_singular(rsp_singular)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Clamp to the 32-bit range
   function automatic longint clamp32(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // Fixed-point product, floor rounding
   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FRAC;
   endfunction

   // Fixed-point quotient, truncated toward zero, saturated
   function automatic longint fx_div(longint n, longint d);
      longint num;
      num = clamp32(n) * (64'sd1 <<< FRAC);
      return clamp32(num / d);
   endfunction

   // Doolittle factor and solve, no pivoting
   function automatic solution_type solve_system(system_type s);
      solution_type r;
      longint a[12];
      longint l21, l31, l32, u22, u23, u33, r2, r3, x1, x2, x3;
      for (int i = 0; i < 12; i++) a[i] = s.v[i];
      for (int i = 0; i < 9; i++) r.f[i] = '0;
      r.sing = 1'b1;
      if (a[0] == 0) return r;
      l21 = fx_div(a[3], a[0]);
      l31 = fx_div(a[6], a[0]);
      u22 = clamp32(a[4] - fx_mul(l21, a[1]));
      u23 = clamp32(a[5] - fx_mul(l21, a[2]));
      if (u22 == 0) return r;
      l32 = fx_div(a[7] - fx_mul(l31, a[1]), u22);
      u33 = clamp32(a[8] - fx_mul(l31, a[2]) - fx_mul(l32, u23));
      if (u33 == 0) return r;
      r2 = clamp32(a[10] - fx_mul(l21, a[9]));
      r3 = clamp32(a[11] - fx_mul(l31, a[9]) - fx_mul(l32, r2));
      x3 = fx_div(r3, u33);
      x2 = fx_div(r2 - fx_mul(u23, x3), u22);
      x1 = fx_div(a[9] - fx_mul(a[1], x2) - fx_mul(a[2], x3), a[0]);
      r.f[0] = x1[31:0];  r.f[1] = x2[31:0];  r.f[2] = x3[31:0];
      r.f[3] = l21[31:0]; r.f[4] = l31[31:0]; r.f[5] = l32[31:0];
      r.f[6] = u22[31:0]; r.f[7] = u23[31:0]; r.f[8] = u33[31:0];
      r.sing = 1'b0;
      return r;
   endfunction

   // Drive one request beat and hold it until taken
   task automatic send_system(system_type s, solution_type expected);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_v <= s.v;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      solution_q.push_back(expected);
   endtask

   task automatic send_predicted(system_type s);
      send_system(s, solve_system(s));
   endtask

   task automatic drain();
      while (solution_q.size() != 0) @(posedge clock);
   endtask

   // Random system: mostly well-conditioned, some dependent rows, some noise
   function automatic system_type random_system();
      system_type s;
      int kind;
      kind = $urandom_range(99);
      for (int i = 0; i < 12; i++) begin
         if (kind < 15) s.v[i] = $urandom;
         else s.v[i] = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      end
      if (kind >= 15) begin
         s.v[0] = s.v[0] + ($urandom_range(1) ? 32 : -32) * ONE;
         s.v[4] = s.v[4] + ($urandom_range(1) ? 32 : -32) * ONE;
         s.v[8] = s.v[8] + ($urandom_range(1) ? 32 : -32) * ONE;
      end
      // copy row 1 into row 2 or row 3, or clear m11, to force a zero pivot
      if (kind >= 15 && kind < 22) begin
         for (int c = 0; c < 3; c++) s.v[3 + c] = s.v[c];
      end else if (kind >= 22 && kind < 28) begin
         for (int c = 0; c < 3; c++) s.v[6 + c] = s.v[c];
      end else if (kind >= 28 && kind < 31) begin
         s.v[0] = '0;
      end
      return s;
   endfunction

   // Check response beats, randomize response stall
   always @(posedge clock) begin
      solution_type e;
      bit bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solution_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at cycle %0d", cycles);
         end else begin
            e = solution_q.pop_front();
            beats_checked++;
            if (e.sing) singular_seen++;
            bad = (rsp_singular !== e.sing);
            for (int i = 0; i < 9; i++) if (rsp_f[i] !== e.f[i]) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on beat %0d: singular exp %0b got %0b",
                           beats_checked, e.sing, rsp_singular);
                  for (int i = 0; i < 9; i++)
                     if (rsp_f[i] !== e.f[i])
                        $display("  field %0d exp %h got %h", i, e.f[i], rsp_f[i]);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Directed rows: zero_pivot rows have their response typed in
   row_type directed[] = '{
      '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 3*ONE, -5*ONE, 7*ONE}, 1'b0},
      '{'{0, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1},
      '{'{0, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX}, 1'b1},
      '{'{ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, ONE}, 1'b1},
      '{'{ONE, 0, 0, 0, ONE, ONE, 0, ONE, ONE, ONE, ONE, ONE}, 1'b1},
      '{'{2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE, ONE, 2*ONE, 3*ONE}, 1'b0},
      '{'{1, 0, 0, PMAX, ONE, 0, NMAX, 0, ONE, PMAX, NMAX, PMAX}, 1'b0},
      '{'{-1, 0, 0, NMAX, ONE, 0, PMAX, 0, ONE, NMAX, PMAX, NMAX}, 1'b0},
      '{'{PMAX, PMAX, PMAX, PMAX, NMAX, PMAX, PMAX, PMAX, NMAX, PMAX, PMAX, PMAX}, 1'b0},
      '{'{NMAX, NMAX, NMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX, NMAX, NMAX}, 1'b0},
      '{'{NMAX, PMAX, 1, -1, NMAX, PMAX, 1, -1, NMAX, -1, 1, 0}, 1'b0},
      '{'{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE,
          ONE, ONE, ONE}, 1'b0},
      '{'{-3*ONE, ONE/2, -ONE/4, ONE/8, -7*ONE, 3, 5, -9, 11*ONE,
          -ONE, 0, ONE}, 1'b0},
      '{'{ONE, 0, 0, 0, 1, 0, 0, 0, 1, PMAX, PMAX, NMAX}, 1'b0}
   };

   initial begin
      system_type s;
      solution_type z;
      for (int i = 0; i < 9; i++) z.f[i] = '0;
      z.sing = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table with no idling
      foreach (directed[k]) begin
         s.v = directed[k].v;
         if (directed[k].zero_pivot) send_system(s, z);
         else send_predicted(s);
      end
      req_valid <= 1'b0;
      drain();

      // Slow response side, then slow request side, then full rate
      send_idle_pct = 22; recv_idle_pct = 73;
      repeat (PHASE_ITEMS) send_predicted(random_system());
      req_valid <= 1'b0;
      drain();
      send_idle_pct = 73; recv_idle_pct = 22;
      repeat (PHASE_ITEMS) send_predicted(random_system());
      req_valid <= 1'b0;
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (PHASE_ITEMS) send_predicted(random_system());
      req_valid <= 1'b0;

      drain();
      repeat (TAIL) @(posedge clock);
      $display("Checked %0d response beats, %0d of them singular, over three idling mixes.",
               beats_checked, singular_seen);
      $display("Mismatch count: %0d, leftover expectations: %0d",
               mismatches, solution_q.size());
      if (mismatches == 0 && solution_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lus_pkg.sv
rtl/core/lus_front.sv
rtl/core/lus_queue.sv
rtl/core/lus_div.sv
rtl/core/lus_back.sv
rtl/core/lu_solve_3x3_unit.sv
sim/tb.sv
